>>> src/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and helpers for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [0:0] {
        CFG_PHASE_TICKS = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } t_cfg_reg;

    localparam logic [7:0] PhaseTicksRst = 8'd2;
    localparam logic [7:0] AckTimeoutRst = 8'd250;
    localparam logic [7:0] CountMax      = 8'hFF;
    localparam logic [3:0] BitsPerByte   = 4'd8;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_WRITE     = 3'd3,
        OP_READ_ACK  = 3'd4,
        OP_READ_NACK = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_S_A    = 5'd1,
        ST_S_B    = 5'd2,
        ST_S_C    = 5'd3,
        ST_P_A    = 5'd4,
        ST_P_B    = 5'd5,
        ST_P_C    = 5'd6,
        ST_P_D    = 5'd7,
        ST_W_PRE  = 5'd8,
        ST_W_DAT  = 5'd9,
        ST_W_HI   = 5'd10,
        ST_W_LO   = 5'd11,
        ST_W_REL  = 5'd12,
        ST_W_WAIT = 5'd13,
        ST_W_AHI  = 5'd14,
        ST_W_ALO  = 5'd15,
        ST_R_LO   = 5'd16,
        ST_R_HI   = 5'd17,
        ST_A_LO   = 5'd18,
        ST_A_BIT  = 5'd19,
        ST_A_HI   = 5'd20,
        ST_A_END  = 5'd21,
        ST_A_REL  = 5'd22
    } t_step;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_missing;
        logic [7:0] rx_byte;
    } t_result;

    // Line levels driven on entry to a phase.
    function automatic t_lines f_enter(t_step s, t_op cmd, logic msb, t_lines cur);
        t_lines l;
        l = cur;
        unique case (s)
            ST_S_A:    begin l.scl = 1'b1; l.sda = 1'b1; end
            ST_S_B:    l.sda = 1'b0;
            ST_S_C:    l.scl = 1'b0;
            ST_P_A:    l.sda = 1'b0;
            ST_P_B:    l.scl = 1'b0;
            ST_P_C:    l.scl = 1'b1;
            ST_P_D:    l.sda = 1'b1;
            ST_W_PRE:  l.scl = 1'b0;
            ST_W_DAT:  l.sda = msb;
            ST_W_HI:   l.scl = 1'b1;
            ST_W_LO:   l.scl = 1'b0;
            ST_W_REL:  begin l.scl = 1'b0; l.sda = 1'b1; end
            ST_W_AHI:  l.scl = 1'b1;
            ST_W_ALO:  l.scl = 1'b0;
            ST_R_LO:   begin l.scl = 1'b0; l.sda = 1'b1; end
            ST_R_HI:   l.scl = 1'b1;
            ST_A_LO:   l.scl = 1'b0;
            ST_A_BIT:  l.sda = (cmd == OP_READ_ACK) ? 1'b0 : 1'b1;
            ST_A_HI:   l.scl = 1'b1;
            ST_A_END:  l.scl = 1'b0;
            ST_A_REL:  l.sda = 1'b1;
            default:   l = cur;
        endcase
        return l;
    endfunction

endpackage

>>> src/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master sequencer advanced by one tick transaction per clock
// while the result channel does not stall.
// A tick transaction passes the input register, then the result register,
// before its result leaves.
// Throughput: one tick transaction per cycle while the result channel does
// not stall, set by the single sequencer update between the two registers.
// Reset (i_rst_n low, synchronous): sequencer idle, lines released, counters,
// shift register and received byte cleared, registers back to defaults.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_operation,
    input  logic [7:0]                  i_tx_byte,
    input  logic                        i_sda_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_scl_out,
    output logic                        o_sda_out,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_ack_missing,
    output logic [7:0]                  o_rx_byte,
    // register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [i2cm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    import i2cm_pkg::*;

    // configuration
    logic [7:0] r_phase_ticks;
    logic [7:0] r_ack_timeout;

    // input register
    logic       r_in_valid;
    logic [2:0] r_in_op;
    logic [7:0] r_in_tx;
    logic       r_in_sda;

    // sequencer state
    t_step      r_step,      n_step;
    t_op        r_cmd,       n_cmd;
    logic [3:0] r_bit_cnt,   n_bit_cnt;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_phase_cnt, n_phase_cnt;
    logic [7:0] r_wait_cnt,  n_wait_cnt;
    t_lines     r_lines,     n_lines;
    logic [7:0] r_rx_hold,   n_rx_hold;

    // result register
    logic       r_out_valid;
    t_result    r_res,       n_res;

    // intermediates of the tick update
    t_lines     w_lines_now;
    logic       w_done;
    logic       w_missing;
    logic       w_out_free;
    logic       w_step_en;
    logic       w_cmd_take;
    logic [7:0] w_cnt_inc;
    logic [3:0] w_bit_inc;

    // Hold the input register while the result register cannot drain.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step_en  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;

    // Take a command only when idle and the code is a real one.
    assign w_cmd_take = (r_step == ST_IDLE) &&
                        (r_in_op == OP_START || r_in_op == OP_STOP ||
                         r_in_op == OP_WRITE || r_in_op == OP_READ_ACK ||
                         r_in_op == OP_READ_NACK);

    // ------------------------------------------------------------------
    // Next state: command entry, then one tick of phase or ACK-wait timing.
    // ------------------------------------------------------------------
    always_comb begin
        n_step      = r_step;
        n_cmd       = r_cmd;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_phase_cnt = r_phase_cnt;
        n_wait_cnt  = r_wait_cnt;
        n_lines     = r_lines;
        n_rx_hold   = r_rx_hold;
        w_done      = 1'b0;
        w_missing   = 1'b0;
        w_cnt_inc   = '0;
        w_bit_inc   = '0;

        // Command entry sets the first phase and its line levels.
        if (w_cmd_take) begin
            n_cmd       = t_op'(r_in_op);
            n_bit_cnt   = '0;
            n_wait_cnt  = '0;
            n_phase_cnt = '0;
            unique case (t_op'(r_in_op))
                OP_START:  n_step = ST_S_A;
                OP_STOP:   n_step = ST_P_A;
                OP_WRITE:  begin n_step = ST_W_PRE; n_shift = r_in_tx; end
                default:   begin n_step = ST_R_LO;  n_shift = '0;      end
            endcase
            n_lines = f_enter(n_step, n_cmd, n_shift[7], n_lines);
        end

        // Levels on the bus this tick.
        w_lines_now = n_lines;

        if (n_step == ST_W_WAIT) begin
            if (!r_in_sda) begin
                // Slave acknowledged: clock the ACK bit.
                n_step      = ST_W_AHI;
                n_phase_cnt = '0;
                n_lines     = f_enter(n_step, n_cmd, n_shift[7], n_lines);
            end else begin
                w_cnt_inc  = (n_wait_cnt == CountMax) ? n_wait_cnt : n_wait_cnt + 8'd1;
                n_wait_cnt = w_cnt_inc;
                if (w_cnt_inc >= r_ack_timeout) begin
                    // No ACK in time: issue a stop.
                    n_step      = ST_P_A;
                    n_phase_cnt = '0;
                    n_lines     = f_enter(n_step, n_cmd, n_shift[7], n_lines);
                end
            end
        end else if (n_step != ST_IDLE) begin
            w_cnt_inc   = (n_phase_cnt == CountMax) ? n_phase_cnt : n_phase_cnt + 8'd1;
            n_phase_cnt = w_cnt_inc;
            if (w_cnt_inc >= r_phase_ticks) begin
                w_bit_inc = n_bit_cnt + 4'd1;
                priority case (n_step)
                    ST_S_A:   n_step = ST_S_B;
                    ST_S_B:   n_step = ST_S_C;
                    ST_P_A:   n_step = ST_P_B;
                    ST_P_B:   n_step = ST_P_C;
                    ST_P_C:   n_step = ST_P_D;
                    ST_W_PRE: n_step = ST_W_DAT;
                    ST_W_DAT: n_step = ST_W_HI;
                    ST_W_HI:  n_step = ST_W_LO;
                    ST_W_LO: begin
                        n_shift   = {n_shift[6:0], 1'b0};
                        n_bit_cnt = w_bit_inc;
                        n_step    = (w_bit_inc >= BitsPerByte) ? ST_W_REL : ST_W_DAT;
                    end
                    ST_W_REL: begin
                        n_step     = ST_W_WAIT;
                        n_wait_cnt = '0;
                    end
                    ST_W_AHI: n_step = ST_W_ALO;
                    ST_R_LO:  n_step = ST_R_HI;
                    ST_R_HI: begin
                        // Sample SDA at the end of SCL high, MSB first.
                        n_shift   = {n_shift[6:0], r_in_sda};
                        n_bit_cnt = w_bit_inc;
                        n_step    = (w_bit_inc >= BitsPerByte) ? ST_A_LO : ST_R_LO;
                    end
                    ST_A_LO:  n_step = ST_A_BIT;
                    ST_A_BIT: n_step = ST_A_HI;
                    ST_A_HI:  n_step = ST_A_END;
                    ST_A_END: n_step = ST_A_REL;
                    default: begin
                        // Last phase of a command: publish and go idle.
                        if (n_step == ST_A_REL) begin
                            n_rx_hold = n_shift;
                        end
                        w_missing = (n_step == ST_P_D) && (n_cmd == OP_WRITE);
                        w_done    = 1'b1;
                        n_step    = ST_IDLE;
                    end
                endcase
                n_phase_cnt = '0;
                if (!w_done) begin
                    n_lines = f_enter(n_step, n_cmd, n_shift[7], n_lines);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result fields of this tick.
    // ------------------------------------------------------------------
    always_comb begin
        n_res.scl_out     = w_lines_now.scl;
        n_res.sda_out     = w_lines_now.sda;
        n_res.busy_res    = (n_step != ST_IDLE);
        n_res.done_res    = w_done;
        n_res.ack_missing = w_missing;
        n_res.rx_byte     = n_rx_hold;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PhaseTicksRst;
            r_ack_timeout <= AckTimeoutRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Indexes beyond the list fall through and are dropped.
            if (i_cfg_index == CfgIdxW'(CFG_PHASE_TICKS)) begin
                r_phase_ticks <= i_cfg_data;
            end else if (i_cfg_index == CfgIdxW'(CFG_ACK_TIMEOUT)) begin
                r_ack_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_op  <= i_operation;
            r_in_tx  <= i_tx_byte;
            r_in_sda <= i_sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_cmd       <= OP_NONE;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_phase_cnt <= '0;
            r_wait_cnt  <= '0;
            r_lines     <= '{scl: 1'b1, sda: 1'b1};
            r_rx_hold   <= '0;
        end else if (w_step_en) begin
            r_step      <= n_step;
            r_cmd       <= n_cmd;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_phase_cnt <= n_phase_cnt;
            r_wait_cnt  <= n_wait_cnt;
            r_lines     <= n_lines;
            r_rx_hold   <= n_rx_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step_en) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_out     = r_res.scl_out;
    assign o_sda_out     = r_res.sda_out;
    assign o_busy_res    = r_res.busy_res;
    assign o_done_res    = r_res.done_res;
    assign o_ack_missing = r_res.ack_missing;
    assign o_rx_byte     = r_res.rx_byte;

endmodule
